// ===== design/ceb_pkg.sv =====
package ceb_pkg;

  // Command codes carried on the input channel
  localparam logic [1:0] CMD_QUERY   = 2'd0;
  localparam logic [1:0] CMD_FAIL    = 2'd1;
  localparam logic [1:0] CMD_SUCCESS = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_DELAY   = 2'd0;
  localparam logic [1:0] REG_MAX_DELAY    = 2'd1;
  localparam logic [1:0] REG_JITTER_RANGE = 2'd2;
  localparam logic [1:0] REG_RETRY_LIMIT  = 2'd3;

  // Register reset values
  localparam logic [31:0] RST_BASE_DELAY   = 32'd1000;
  localparam logic [31:0] RST_MAX_DELAY    = 32'd60000;
  localparam logic [31:0] RST_JITTER_RANGE = 32'd5000;
  localparam logic [31:0] RST_RETRY_LIMIT  = 32'hFFFF_FFFF;

  // Largest exponent applied to the base delay
  localparam logic [4:0]  SHIFT_CAP = 5'd30;

  // Restoring divider for the jitter remainder, one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAP,
    ST_DIV,
    ST_DONE
  } ceb_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input beat
    logic cap;       // register capped delay, arm the divider
    logic div_step;  // one restoring divide step
    logic finish;    // write result, update counter
  } ceb_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_fail;   // captured command is a failure
    logic jit_zero;  // jitter disabled
    logic div_last;  // divider on its final step
    logic out_free;  // output register can take a result
  } ceb_sts_t;

endpackage

// ===== design/ceb_ctrl.sv =====
module ceb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ceb_pkg::ceb_sts_t sts,
  output ceb_pkg::ceb_ctl_t ctl
);
  import ceb_pkg::*;

  ceb_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_CAP;
        end
      end
      ST_CAP: begin
        ctl.cap = 1'b1;
        if (sts.is_fail && !sts.jit_zero) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for room in the output register
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ceb_dp.sv =====
module ceb_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        cmd,
  input  logic [31:0]       random_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       delay_ms,
  output logic              retry_allowed,
  output logic [31:0]       attempt_count,
  input  ceb_pkg::ceb_ctl_t ctl,
  output ceb_pkg::ceb_sts_t sts
);
  import ceb_pkg::*;

  logic [31:0] base_reg;
  logic [31:0] cap_reg;
  logic [31:0] jitter_range;
  logic [31:0] retry_limit;
  logic [31:0] retry_counter;

  logic [1:0]        cmd_q;
  logic [31:0]       dvd;
  logic [31:0]       rem;
  logic [STEP_W-1:0] step_cnt;
  logic [31:0]       capped;

  logic [4:0]  shamt;
  logic [63:0] wide;
  logic [31:0] capped_next;
  logic [32:0] rem_shift;
  logic [32:0] rem_sub;
  logic [31:0] jitter;
  logic [32:0] sum;
  logic [31:0] sat_delay;
  logic [31:0] retry_counter_next;
  logic        allowed_next;
  logic        is_fail;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg     <= RST_BASE_DELAY;
      cap_reg      <= RST_MAX_DELAY;
      jitter_range <= RST_JITTER_RANGE;
      retry_limit  <= RST_RETRY_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_DELAY:   base_reg     <= cfg_data;
        REG_MAX_DELAY:    cap_reg      <= cfg_data;
        REG_JITTER_RANGE: jitter_range <= cfg_data;
        REG_RETRY_LIMIT:  retry_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_fail = (cmd_q == CMD_FAIL);

  // Exponential part, taken wide, then capped
  always_comb begin
    shamt       = (retry_counter >= 32'(SHIFT_CAP)) ? SHIFT_CAP : retry_counter[4:0];
    wide        = {32'd0, base_reg} << shamt;
    capped_next = (wide > {32'd0, cap_reg}) ? cap_reg : wide[31:0];
  end

  // Restoring divide step for random_word mod jitter_range
  always_comb begin
    rem_shift = {rem, dvd[31]};
    rem_sub   = rem_shift - {1'b0, jitter_range};
  end

  // Capture the beat, then run the divider
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      dvd   <= random_word;
    end
    if (ctl.cap) begin
      capped   <= capped_next;
      rem      <= '0;
      step_cnt <= '0;
    end else if (ctl.div_step) begin
      rem      <= rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];
      dvd      <= {dvd[30:0], 1'b0};
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  // Final delay and counter update
  always_comb begin
    jitter    = (jitter_range != '0) ? rem : '0;
    sum       = {1'b0, capped} + {1'b0, jitter};
    sat_delay = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    retry_counter_next = retry_counter;
    if (is_fail) begin
      if (retry_counter != 32'hFFFF_FFFF) begin
        retry_counter_next = retry_counter + 32'd1;
      end
    end else if (cmd_q == CMD_SUCCESS) begin
      retry_counter_next = '0;
    end
    allowed_next = retry_limit[31] || (retry_counter_next < retry_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_counter <= '0;
    end else if (ctl.finish) begin
      retry_counter <= retry_counter_next;
    end
  end

  // Output register, holds until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      delay_ms      <= is_fail ? sat_delay : '0;
      retry_allowed <= allowed_next;
      attempt_count <= retry_counter_next;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.is_fail  = is_fail;
    sts.jit_zero = (jitter_range == '0);
    sts.div_last = (step_cnt == STEP_W'(DIV_STEPS - 1));
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// ===== design/capped_exponential_backoff.sv =====
// Sequence: the input beat is captured in IDLE, the capped delay is registered
//   in CAP, a failure with jitter enabled runs the restoring divider in DIV, and
//   DONE writes the result once the output register has room. A new item is
//   taken only in IDLE, after the last one is through; a pending result waits
//   in the output register while the next item is taken.
// Reset (rst, synchronous): counter cleared, registers to defaults, no result.
module capped_exponential_backoff (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] random_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] delay_ms,
  output logic        retry_allowed,
  output logic [31:0] attempt_count
);
  import ceb_pkg::*;

  ceb_ctl_t ctl;
  ceb_sts_t sts;

  ceb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ceb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .random_word   (random_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .delay_ms      (delay_ms),
    .retry_allowed (retry_allowed),
    .attempt_count (attempt_count),
    .ctl           (ctl),
    .sts           (sts)
  );

endmodule

// ===== design/ceb_checker.sv =====
module ceb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] delay_ms,
  input logic [31:0] attempt_count
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(delay_ms) && $stable(attempt_count))
    else $error("stalled result changed");

  // One item at a time: no beat right after a beat
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A nonzero delay only comes from a failure, which leaves the counter above zero
  a_delay_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (delay_ms != 32'd0) |-> attempt_count != 32'd0)
    else $error("delay with zero attempt count");

  // Drop any result on reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind capped_exponential_backoff ceb_checker u_ceb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .delay_ms      (delay_ms),
  .attempt_count (attempt_count)
);
